@@ rtl/utf8san_pkg.sv @@
package utf8san_pkg;

    // Byte patterns used when classifying UTF-8 leads
    localparam logic [7:0] REPL_CHAR     = 8'h3F;
    localparam logic [7:0] MASK_2BYTE    = 8'hE0;
    localparam logic [7:0] MASK_3BYTE    = 8'hF0;
    localparam logic [7:0] MASK_4BYTE    = 8'hF8;
    localparam logic [7:0] MASK_CONT     = 8'hC0;
    localparam logic [7:0] TAG_CONT      = 8'h80;
    localparam logic [7:0] TAG_2BYTE     = 8'hC0;
    localparam logic [7:0] TAG_3BYTE     = 8'hE0;
    localparam logic [7:0] TAG_4BYTE     = 8'hF0;
    localparam logic [7:0] MIN_2BYTE     = 8'hC2;
    localparam logic [7:0] MAX_4BYTE     = 8'hF4;

    // Output queue geometry
    localparam int unsigned QUEUE_DEPTH  = 8;
    localparam int unsigned PTR_W        = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned MAX_RESULTS  = 4;
    localparam int unsigned HOLD_DEPTH   = 3;

    // Lead byte classification: ok=0 means an invalid lead
    typedef struct packed {
        logic       ok;
        logic [1:0] extra;
    } lead_info_t;

    // One queued output transaction
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_entry_t;

    function automatic lead_info_t lead_decode(input logic [7:0] b);
        lead_info_t info;
        info.ok    = 1'b0;
        info.extra = 2'd0;
        if (b[7] == 1'b0)
        begin
            info.ok = 1'b1;
        end
        else if ((b & MASK_2BYTE) == TAG_2BYTE)
        begin
            info.ok    = (b >= MIN_2BYTE);
            info.extra = 2'd1;
        end
        else if ((b & MASK_3BYTE) == TAG_3BYTE)
        begin
            info.ok    = 1'b1;
            info.extra = 2'd2;
        end
        else if ((b & MASK_4BYTE) == TAG_4BYTE)
        begin
            info.ok    = (b <= MAX_4BYTE);
            info.extra = 2'd3;
        end
        return info;
    endfunction

endpackage

@@ rtl/utf8_sanitize_replace.sv @@
// Channel | Direction | Handshake            | Payload
// in      | sink      | in_valid / in_stall  | in_byte[7:0], in_last
// out     | source    | out_valid / out_stall| out_byte[7:0], out_last
//
// Each accepted byte is decoded in the cycle it arrives and its 0..4 output bytes are
// written to an 8-entry output queue, drained one byte per cycle if out_stall is low.
// With out_stall low the sustained rate is one byte per cycle; a byte that completes
// or breaks a sequence pushes up to four bytes; in_stall rises with over four queued.
// in_stall depends only on the queue fill count, never on out_stall.
// rst_n (asynchronous, active low) empties the queue and clears the held sequence.
module utf8_sanitize_replace
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last
);

    localparam int unsigned PTR_W = utf8san_pkg::PTR_W;
    localparam int unsigned CNT_W = utf8san_pkg::CNT_W;

    // Held sequence state
    logic [7:0] held_reg [utf8san_pkg::HOLD_DEPTH];
    logic [7:0] held_next [utf8san_pkg::HOLD_DEPTH];
    logic [1:0] held_count_reg, held_count_next;
    logic [1:0] needed_count_reg, needed_count_next;

    // Output queue
    utf8san_pkg::out_entry_t queue_mem [utf8san_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    // Per-transaction results
    logic [7:0] res [utf8san_pkg::MAX_RESULTS];
    logic [2:0] res_cnt;

    logic in_take;
    logic out_take;

    assign in_stall  = (count_reg > CNT_W'(utf8san_pkg::QUEUE_DEPTH - utf8san_pkg::MAX_RESULTS));
    assign in_take   = in_valid && !in_stall;
    assign out_valid = (count_reg != '0);
    assign out_take  = out_valid && !out_stall;
    assign out_byte  = queue_mem[rd_ptr_reg].data;
    assign out_last  = queue_mem[rd_ptr_reg].last;

    // Decode one input byte against the held sequence
    always_comb
    begin
        utf8san_pkg::lead_info_t lead;
        logic is_cont;
        logic take_new;
        lead              = utf8san_pkg::lead_decode(in_byte);
        is_cont           = ((in_byte & utf8san_pkg::MASK_CONT) == utf8san_pkg::TAG_CONT);
        take_new          = 1'b0;
        res_cnt           = 3'd0;
        held_next         = held_reg;
        held_count_next   = held_count_reg;
        needed_count_next = needed_count_reg;
        for (int k = 0; k < utf8san_pkg::MAX_RESULTS; k++)
        begin
            res[k] = utf8san_pkg::REPL_CHAR;
        end

        if (held_count_reg == 2'd0)
        begin
            take_new = 1'b1;
        end
        else if (is_cont)
        begin
            if (held_count_reg >= needed_count_reg)
            begin
                // complete sequence: release held bytes and this one
                for (int i = 0; i < utf8san_pkg::HOLD_DEPTH; i++)
                begin
                    if (2'(i) < held_count_reg)
                    begin
                        res[res_cnt[1:0]] = held_reg[i];
                        res_cnt           = res_cnt + 3'd1;
                    end
                end
                res[res_cnt[1:0]] = in_byte;
                res_cnt           = res_cnt + 3'd1;
                held_count_next   = 2'd0;
                needed_count_next = 2'd0;
            end
            else if (in_last)
            begin
                // truncated at end of string
                res_cnt           = {1'b0, held_count_reg} + 3'd1;
                held_count_next   = 2'd0;
                needed_count_next = 2'd0;
            end
            else
            begin
                held_next[held_count_reg] = in_byte;
                held_count_next           = held_count_reg + 2'd1;
            end
        end
        else
        begin
            // broken sequence: one replacement per held byte, then retry as lead
            res_cnt           = {1'b0, held_count_reg};
            held_count_next   = 2'd0;
            needed_count_next = 2'd0;
            take_new          = 1'b1;
        end

        if (take_new)
        begin
            if (lead.ok && lead.extra == 2'd0)
            begin
                res[res_cnt[1:0]] = in_byte;
                res_cnt           = res_cnt + 3'd1;
            end
            else if (!lead.ok || in_last)
            begin
                res[res_cnt[1:0]] = utf8san_pkg::REPL_CHAR;
                res_cnt           = res_cnt + 3'd1;
            end
            else
            begin
                held_next[0]      = in_byte;
                held_count_next   = 2'd1;
                needed_count_next = lead.extra;
            end
        end
    end

    // Queue fill count
    always_comb
    begin
        count_next = count_reg;
        if (in_take)
        begin
            count_next = count_next + CNT_W'(res_cnt);
        end
        if (out_take)
        begin
            count_next = count_next - CNT_W'(1);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg   <= 2'd0;
            needed_count_reg <= 2'd0;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            count_reg        <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (in_take)
            begin
                held_count_reg   <= held_count_next;
                needed_count_reg <= needed_count_next;
                wr_ptr_reg       <= wr_ptr_reg + PTR_W'(res_cnt);
            end
            if (out_take)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    // Held bytes and queue storage (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            held_reg <= held_next;
            for (int k = 0; k < utf8san_pkg::MAX_RESULTS; k++)
            begin
                if (3'(k) < res_cnt)
                begin
                    queue_mem[wr_ptr_reg + PTR_W'(k)].data <= res[k];
                    queue_mem[wr_ptr_reg + PTR_W'(k)].last <= in_last && (3'(k + 1) == res_cnt);
                end
            end
        end
    end

    // Queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(utf8san_pkg::QUEUE_DEPTH))
        else $error("output queue overflow");

    // A held sequence always has a lead that called for it
    assert property (@(posedge clk) disable iff (!rst_n)
        (held_count_reg != 2'd0) |-> (needed_count_reg != 2'd0 &&
                                      held_count_reg <= needed_count_reg))
        else $error("held count out of range");

    // End of string returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && in_last) |=> (held_count_reg == 2'd0))
        else $error("sequence held past end of string");

    // End of string always leaves something to send
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && in_last) |=> (count_reg != '0))
        else $error("end of string produced no output");

endmodule
